@@ rtl/core/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle plane slicer package
// Shared widths, codes and beat types of the slicer pipeline.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 24;
  localparam int SCALE_FRAC = 16;
  localparam int UFRAC      = 30;
  localparam int QW         = UFRAC + 1;
  localparam int NVERT      = 3;
  localparam int NSEG       = 3;
  localparam int XFORM_LAT  = 2;
  localparam int LANE_LAT   = 1 + QW + 2;
  localparam int PIPE_DEPTH = XFORM_LAT + LANE_LAT;

  typedef enum logic [1:0] {
    CFG_PLANE_Z  = 2'd0,
    CFG_OFFSET_X = 2'd1,
    CFG_OFFSET_Y = 2'd2,
    CFG_SCALE    = 2'd3
  } cfg_idx_t;

  localparam logic KIND_COPLANAR = 1'b0;
  localparam logic KIND_CROSS    = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      seg_kind;
    logic                      last_of_run;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vert_t;

  typedef struct packed {
    logic                      cop;
    logic                      hit;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
  } side_t;

  typedef struct packed {
    logic                      cop;
    logic                      hit;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } lane_res_t;

endpackage

@@ rtl/core/tps_xform.sv @@
// ----------------------------------------------------------------------------
// Vertex transform
// Scales all nine coordinates, adds the x and y offsets and saturates.
// ----------------------------------------------------------------------------
module tps_xform (
  input  logic                          clk,
  input  logic                          en,
  input  tps_pkg::in_t                  in_data,
  input  logic signed [tps_pkg::COORD_W-1:0] offset_x,
  input  logic signed [tps_pkg::COORD_W-1:0] offset_y,
  input  logic [tps_pkg::SCALE_W-1:0]   scale_factor,
  output tps_pkg::vert_t                verts [tps_pkg::NVERT]
);
  import tps_pkg::*;

  localparam int NC    = 3 * NVERT;
  localparam int PW    = COORD_W + SCALE_W + 1;
  localparam int SW    = PW - SCALE_FRAC + 1;

  logic signed [COORD_W-1:0] coord [NC];
  logic signed [PW-1:0]      prod  [NC];
  logic signed [COORD_W-1:0] res   [NC];

  assign coord[0] = in_data.ax;
  assign coord[1] = in_data.ay;
  assign coord[2] = in_data.az;
  assign coord[3] = in_data.bx;
  assign coord[4] = in_data.by_coord;
  assign coord[5] = in_data.bz;
  assign coord[6] = in_data.cx;
  assign coord[7] = in_data.cy;
  assign coord[8] = in_data.cz;

  for (genvar i = 0; i < NC; i++) begin : g_coord
    logic signed [COORD_W-1:0] off;
    logic signed [SW-1:0]      sum;

    if (i % 3 == 0) begin : g_x
      assign off = offset_x;
    end else if (i % 3 == 1) begin : g_y
      assign off = offset_y;
    end else begin : g_z
      assign off = '0;
    end

    assign sum = $signed({prod[i][PW-1], prod[i][PW-1:SCALE_FRAC]})
               + $signed({{(SW-COORD_W){off[COORD_W-1]}}, off});

    always_ff @(posedge clk) begin
      if (en) begin
        prod[i] <= coord[i] * $signed({1'b0, scale_factor});
        if (sum > $signed({{(SW-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}})) begin
          res[i] <= {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum < $signed({{(SW-COORD_W){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}})) begin
          res[i] <= {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          res[i] <= sum[COORD_W-1:0];
        end
      end
    end
  end

  for (genvar v = 0; v < NVERT; v++) begin : g_vert
    assign verts[v].x = res[3*v];
    assign verts[v].y = res[3*v+1];
    assign verts[v].z = res[3*v+2];
  end

endmodule

@@ rtl/core/tps_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined crossing divider
// Restoring division, one quotient bit per stage, of num * 2^30 / den
// for num <= den, carrying the edge data alongside.
// ----------------------------------------------------------------------------
module tps_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tps_pkg::COORD_W-1:0]  num,
  input  logic [tps_pkg::COORD_W-1:0]  den,
  input  tps_pkg::side_t               side_in,
  output logic [tps_pkg::QW-1:0]       quo,
  output tps_pkg::side_t               side_out
);
  import tps_pkg::*;

  logic [COORD_W:0]   rem_r  [1:QW];
  logic [COORD_W-1:0] den_r  [1:QW];
  logic [QW-1:0]      quo_r  [1:QW];
  side_t              side_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [COORD_W:0]   r_in;
    logic [COORD_W-1:0] d_in;
    logic [QW-1:0]      q_in;
    side_t              s_in;
    logic [COORD_W:0]   diff;
    logic               take;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_rest
      assign r_in = rem_r[k];
      assign d_in = den_r[k];
      assign q_in = quo_r[k];
      assign s_in = side_r[k];
    end

    assign take = r_in >= {1'b0, d_in};
    assign diff = r_in - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? {diff[COORD_W-1:0], 1'b0} : {r_in[COORD_W-1:0], 1'b0};
        den_r[k+1]  <= d_in;
        quo_r[k+1]  <= {q_in[QW-2:0], take};
        side_r[k+1] <= s_in;
      end
    end
  end

  assign quo      = quo_r[QW];
  assign side_out = side_r[QW];

endmodule

@@ rtl/core/tps_lane.sv @@
// ----------------------------------------------------------------------------
// Edge lane
// Tests one edge against the plane and interpolates its crossing point.
// ----------------------------------------------------------------------------
module tps_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tps_pkg::COORD_W-1:0] plane_z,
  input  tps_pkg::vert_t                     v1,
  input  tps_pkg::vert_t                     v2,
  output tps_pkg::lane_res_t                 res
);
  import tps_pkg::*;

  localparam int MW = COORD_W + 1 + QW + 1;

  logic signed [COORD_W:0]   dz;
  logic signed [COORD_W:0]   num;
  logic signed [COORD_W:0]   neg_dz;
  logic signed [COORD_W:0]   neg_num;
  logic                      hit;
  side_t                     side_a;
  side_t                     side_a_next;
  logic [COORD_W-1:0]        an;
  logic [COORD_W-1:0]        ad;
  logic [QW-1:0]             quo;
  side_t                     side_d;
  side_t                     side_m;
  logic signed [MW-1:0]      mx;
  logic signed [MW-1:0]      my;
  logic signed [MW-UFRAC-1:0] sx;
  logic signed [MW-UFRAC-1:0] sy;

  assign dz      = $signed({v2.z[COORD_W-1], v2.z}) - $signed({v1.z[COORD_W-1], v1.z});
  assign num     = $signed({plane_z[COORD_W-1], plane_z}) - $signed({v1.z[COORD_W-1], v1.z});
  assign neg_dz  = -dz;
  assign neg_num = -num;

  always_comb begin
    hit = 1'b0;
    if (dz > 0) begin
      hit = (num >= 0) && (num <= dz);
    end else if (dz < 0) begin
      hit = (num <= 0) && (num >= dz);
    end
    side_a_next.cop = (dz == 0) && (v1.z == plane_z);
    side_a_next.hit = hit;
    side_a_next.x1  = v1.x;
    side_a_next.y1  = v1.y;
    side_a_next.x2  = v2.x;
    side_a_next.y2  = v2.y;
    side_a_next.dx  = $signed({v2.x[COORD_W-1], v2.x}) - $signed({v1.x[COORD_W-1], v1.x});
    side_a_next.dy  = $signed({v2.y[COORD_W-1], v2.y}) - $signed({v1.y[COORD_W-1], v1.y});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= side_a_next;
      an     <= num[COORD_W] ? neg_num[COORD_W-1:0] : num[COORD_W-1:0];
      ad     <= dz[COORD_W] ? neg_dz[COORD_W-1:0] : dz[COORD_W-1:0];
    end
  end

  tps_div u_div (
    .clk      (clk),
    .en       (en),
    .num      (an),
    .den      (ad),
    .side_in  (side_a),
    .quo      (quo),
    .side_out (side_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_m <= side_d;
      mx     <= side_d.dx * $signed({1'b0, quo});
      my     <= side_d.dy * $signed({1'b0, quo});
    end
  end

  assign sx = $signed({{(MW-UFRAC-COORD_W){side_m.x1[COORD_W-1]}}, side_m.x1})
            + mx[MW-1:UFRAC];
  assign sy = $signed({{(MW-UFRAC-COORD_W){side_m.y1[COORD_W-1]}}, side_m.y1})
            + my[MW-1:UFRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      res.cop <= side_m.cop;
      res.hit <= side_m.hit;
      res.x1  <= side_m.x1;
      res.y1  <= side_m.y1;
      res.x2  <= side_m.x2;
      res.y2  <= side_m.y2;
      res.px  <= sx[COORD_W-1:0];
      res.py  <= sy[COORD_W-1:0];
    end
  end

endmodule

@@ rtl/core/tps_merge.sv @@
// ----------------------------------------------------------------------------
// Segment merge and output stage
// Orders the lane findings into segments and hands them out one per beat.
// ----------------------------------------------------------------------------
module tps_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  tps_pkg::lane_res_t lanes [tps_pkg::NVERT],
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output tps_pkg::out_t      out_data
);
  import tps_pkg::*;

  out_t       list [NSEG];
  logic [1:0] cnt;
  logic [1:0] nhit;
  out_t       cross_seg;

  out_t       segs [NSEG];
  logic [1:0] nres;
  logic [1:0] idx;
  logic       busy;
  logic       is_last;

  always_comb begin
    nhit = '0;
    for (int e = 0; e < NVERT; e++) begin
      nhit = nhit + {1'b0, lanes[e].hit};
    end
    cross_seg.seg_kind    = KIND_CROSS;
    cross_seg.last_of_run = 1'b0;
    cross_seg.start_x     = lanes[0].hit ? lanes[0].px : lanes[1].px;
    cross_seg.start_y     = lanes[0].hit ? lanes[0].py : lanes[1].py;
    cross_seg.end_x       = (lanes[0].hit && lanes[1].hit) ? lanes[1].px : lanes[2].px;
    cross_seg.end_y       = (lanes[0].hit && lanes[1].hit) ? lanes[1].py : lanes[2].py;
  end

  always_comb begin
    cnt = '0;
    for (int s = 0; s < NSEG; s++) begin
      list[s] = '0;
    end
    for (int e = 0; e < NVERT; e++) begin
      if (lanes[e].cop && cnt < 2'(NSEG)) begin
        list[cnt].start_x     = lanes[e].x1;
        list[cnt].start_y     = lanes[e].y1;
        list[cnt].end_x       = lanes[e].x2;
        list[cnt].end_y       = lanes[e].y2;
        list[cnt].seg_kind    = KIND_COPLANAR;
        list[cnt].last_of_run = 1'b0;
        cnt = cnt + 2'd1;
      end
    end
    if (nhit == 2'd2 && cnt < 2'(NSEG)) begin
      list[cnt] = cross_seg;
      cnt = cnt + 2'd1;
    end
  end

  assign is_last   = (idx == nres - 2'd1);
  assign adv       = !busy || (out_ready && is_last);
  assign out_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      nres <= '0;
    end else if (adv) begin
      busy <= valid_in && (cnt != 2'd0);
      idx  <= '0;
      nres <= cnt;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSEG; s++) begin
        segs[s] <= list[s];
      end
    end
  end

  always_comb begin
    unique case (idx)
      2'd0:    out_data = segs[0];
      2'd1:    out_data = segs[1];
      default: out_data = segs[2];
    endcase
    out_data.last_of_run = is_last;
  end

endmodule

@@ rtl/core/triangle_plane_slicer_top.sv @@
// ----------------------------------------------------------------------------
// Triangle plane slicer; a triangle's first segment is offered once its beat has passed the register path.
// That path holds 2 transform, 1 edge test, 31 divide, 2 interpolate and 1 output register.
// Throughput: one triangle per cycle, but in_ready is low until a run's last segment is taken.
// Reset: synchronous; empties the pipeline and restores the configuration and control registers.
// ----------------------------------------------------------------------------
module triangle_plane_slicer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tps_pkg::COORD_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tps_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tps_pkg::out_t               out_data
);
  import tps_pkg::*;

  logic signed [COORD_W-1:0] plane_z;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  logic [SCALE_W-1:0]        scale_factor;
  logic                      adv;
  logic [PIPE_DEPTH-1:0]     vpipe;
  vert_t                     verts [NVERT];
  lane_res_t                 lanes [NVERT];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_z      <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      scale_factor <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PLANE_Z:  plane_z      <= cfg_data;
        CFG_OFFSET_X: offset_x     <= cfg_data;
        CFG_OFFSET_Y: offset_y     <= cfg_data;
        CFG_SCALE:    scale_factor <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], in_valid};
    end
  end

  tps_xform u_xform (
    .clk          (clk),
    .en           (adv),
    .in_data      (in_data),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .scale_factor (scale_factor),
    .verts        (verts)
  );

  for (genvar e = 0; e < NVERT; e++) begin : g_lane
    localparam int K = (e == NVERT - 1) ? 0 : e + 1;
    tps_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .plane_z (plane_z),
      .v1      (verts[e]),
      .v2      (verts[K]),
      .res     (lanes[e])
    );
  end

  tps_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (vpipe[PIPE_DEPTH-1]),
    .lanes     (lanes),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
